FILE: hdl/assert_macros.svh
// Assertion helpers for the RTL, included by aae_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is high
`define AAE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset
`define AAE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/aae_pkg.sv
package aae_pkg;

  localparam int SYM_W    = 8;
  localparam int BYTE_W   = 8;
  localparam int CNT_W    = 16;
  localparam int BND_W    = 16;
  localparam int NUM_W    = 32;
  localparam int DIV_STEPS = 32;

  localparam logic OP_CODE   = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [1:0] REG_LENGTH = 2'd0;
  localparam logic [1:0] REG_INCR   = 2'd1;
  localparam logic [1:0] REG_LIMIT  = 2'd2;

  localparam logic [BND_W-1:0] TOP_MASK    = 16'h8000;
  localparam logic [BND_W-1:0] SECOND_MASK = 16'h4000;
  localparam logic [BND_W-1:0] HIGH_RESET  = 16'hFFFF;

  typedef struct packed {
    logic             op;
    logic [SYM_W-1:0] sym;
  } aae_item_t;

  typedef struct packed {
    logic [31:0] length;
    logic [5:0]  incr;
    logic [13:0] limit;
  } aae_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HDR,
    ST_SWEEP,
    ST_MUL,
    ST_DIV,
    ST_RENORM,
    ST_PEND,
    ST_FIN,
    ST_PAD,
    ST_DONE
  } aae_state_t;

endpackage

FILE: hdl/aae_front.sv
module aae_front
  import aae_pkg::*;
#(
  parameter int ALPHABET = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [SYM_W-1:0] s_tdata,
  input  logic             s_tuser,
  output logic             q_valid,
  output aae_item_t        q_item,
  input  logic             q_pop
);

  aae_item_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  aae_item_t  item_in;
  logic       push;

  // clamp symbols beyond the alphabet onto its last entry
  always_comb begin
    item_in.op  = s_tuser;
    item_in.sym = s_tdata;
    if (s_tuser == OP_CODE && {1'b0, s_tdata} >= (SYM_W+1)'(ALPHABET)) begin
      item_in.sym = SYM_W'(ALPHABET - 1);
    end
  end

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

FILE: hdl/aae_div.sv
module aae_div
  import aae_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [CNT_W-1:0] den,
  output logic             done,
  output logic [BND_W-1:0] quo
);

  logic [NUM_W-1:0] dvd;
  logic [CNT_W:0]   rem;
  logic [CNT_W-1:0] den_q;
  logic [5:0]       steps;
  logic             busy;
  logic [CNT_W:0]   trial;
  logic             ge;

  // one quotient bit per cycle, restoring
  assign trial = {rem[CNT_W-1:0], dvd[NUM_W-1]};
  assign ge    = (trial >= {1'b0, den_q});
  assign quo   = dvd[BND_W-1:0];

  always_ff @(posedge clk) begin
    if (start) begin
      dvd   <= num;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      rem <= ge ? (trial - {1'b0, den_q}) : trial;
      dvd <= {dvd[NUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= 6'(DIV_STEPS);
      end else if (busy) begin
        steps <= steps - 6'd1;
        if (steps == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hdl/aae_back.sv
module aae_back
  import aae_pkg::*;
#(
  parameter int ALPHABET    = 256,
  parameter int PENDING_MAX = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  aae_cfg_t          cfg,
  input  logic              q_valid,
  input  aae_item_t         q_item,
  output logic              q_pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [BYTE_W-1:0] m_tdata,
  output logic              m_tlast,
  output logic [1:0]        m_tuser
);

`include "assert_macros.svh"

  localparam int IDX_W = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int PW    = $clog2(PENDING_MAX + 2);

  aae_state_t state, state_next;

  logic              fin;
  logic [IDX_W-1:0]  sym;
  logic [1:0]        hcnt;
  logic              header_sent;
  logic [BND_W-1:0]  lo, hi;
  logic [PW-1:0]     pending;
  logic [BYTE_W-1:0] acc;
  logic [2:0]        fill;
  logic              ovf_seen;
  logic [4:0]        k_cnt;
  logic              bitval;

  logic [CNT_W-1:0]  mem [ALPHABET];
  logic [ALPHABET-1:0] valid_bits;
  logic [CNT_W-1:0]  rd_data;
  logic              rd_v;
  logic              pipe_v;
  logic [IDX_W-1:0]  pipe_idx;
  logic [IDX_W:0]    issue;
  logic [CNT_W-1:0]  acc_sum, cum_lo, cum_hi, total, total_acc, div_total;
  logic              rescale;
  logic              mul_sel;
  logic [BND_W-1:0]  q_hi;

  logic              emit_req, emit_val, hdr_req, flush_req, div_start;
  logic              push_ok, bit_ok, emit_fire, push_fire, flush_fire;
  logic [BYTE_W-1:0] push_data;
  logic              div_done;
  logic [BND_W-1:0]  div_q;

  logic              hold_valid, hold_ovf;
  logic [BYTE_W-1:0] hold_byte;
  logic              out_valid, out_last, out_eos, out_ovf;
  logic [BYTE_W-1:0] out_byte;

  logic [NUM_W-1:0]  range32;
  logic [47:0]       prod_full;
  logic [CNT_W-1:0]  cnt, half, base, nval;
  logic              sweep_end, eq_top, underflow;
  logic [PW-1:0]     pend_inc;

  assign push_ok    = !hold_valid || !out_valid || m_tready;
  assign bit_ok     = (fill != 3'd7) || push_ok;
  assign emit_fire  = emit_req && bit_ok;
  assign push_fire  = (hdr_req && push_ok) || (emit_fire && fill == 3'd7);
  assign flush_fire = flush_req && push_ok;
  assign push_data  = hdr_req ? cfg.length[8*hcnt +: 8] : {acc[6:0], emit_val};

  assign sweep_end = (issue == (IDX_W+1)'(ALPHABET)) && !pipe_v;
  assign eq_top    = (lo[15] == hi[15]);
  assign underflow = lo[14] && !hi[14];
  assign pend_inc  = (pending < PW'(PENDING_MAX)) ? pending + PW'(1) : pending;

  assign range32   = {16'b0, hi} - {16'b0, lo} + 32'd1;
  assign prod_full = {16'b0, range32} * {32'b0, (mul_sel ? cum_lo : cum_hi)};

  assign cnt  = rd_v ? rd_data : 16'd1;
  assign half = 16'(({1'b0, cnt} + 17'd1) >> 1);
  assign base = rescale ? half : cnt;
  assign nval = base + ((pipe_idx == sym) ? {10'b0, cfg.incr} : 16'd0);

  aae_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (prod_full[NUM_W-1:0]),
    .den   (div_total),
    .done  (div_done),
    .quo   (div_q)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (q_valid) state_next = !header_sent ? ST_HDR :
                                           (q_item.op == OP_FINISH) ? ST_FIN : ST_SWEEP;
      ST_HDR:    if (push_ok && hcnt == 2'd3) state_next = fin ? ST_FIN : ST_SWEEP;
      ST_SWEEP:  if (sweep_end) state_next = ST_MUL;
      ST_MUL:    state_next = ST_DIV;
      ST_DIV:    if (div_done) state_next = mul_sel ? ST_RENORM : ST_MUL;
      ST_RENORM: begin
        if (k_cnt == 5'd16) state_next = ST_DONE;
        else if (eq_top) begin
          if (emit_fire) state_next = ST_PEND;
        end else if (!underflow) state_next = ST_DONE;
      end
      ST_PEND:   if (pending == '0) state_next = fin ? ST_PAD : ST_RENORM;
      ST_FIN:    if (emit_fire) state_next = ST_PEND;
      ST_PAD:    if (fill == 3'd0) state_next = ST_DONE;
      ST_DONE:   if (flush_fire) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    emit_req  = 1'b0;
    emit_val  = 1'b0;
    hdr_req   = 1'b0;
    flush_req = 1'b0;
    div_start = 1'b0;
    q_pop     = 1'b0;
    case (state)
      ST_IDLE:   q_pop = q_valid;
      ST_HDR:    hdr_req = 1'b1;
      ST_MUL:    div_start = 1'b1;
      ST_RENORM: begin
        emit_req = (k_cnt != 5'd16) && eq_top;
        emit_val = lo[15];
      end
      ST_PEND: begin
        emit_req = (pending != '0);
        emit_val = bitval;
      end
      ST_FIN: begin
        emit_req = 1'b1;
        emit_val = lo[14];
      end
      ST_PAD: begin
        emit_req = (fill != 3'd0);
        emit_val = 1'b1;
      end
      ST_DONE:   flush_req = 1'b1;
      default:   ;
    endcase
  end

  // count store, read registered in the cycle before the update stage
  always_ff @(posedge clk) begin
    rd_data <= mem[issue[IDX_W-1:0]];
    if (pipe_v) mem[pipe_idx] <= nval;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      valid_bits  <= '0;
      header_sent <= 1'b0;
      ovf_seen    <= 1'b0;
      lo          <= '0;
      hi          <= HIGH_RESET;
      pending     <= '0;
      acc         <= '0;
      fill        <= '0;
      k_cnt       <= '0;
      total       <= CNT_W'(ALPHABET);
      pipe_v      <= 1'b0;
      issue       <= '0;
      hold_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;

      if (q_pop) begin
        fin       <= q_item.op;
        sym       <= q_item.sym[IDX_W-1:0];
        hcnt      <= 2'd0;
        issue     <= '0;
        acc_sum   <= '0;
        total_acc <= '0;
        mul_sel   <= 1'b0;
        rescale   <= (total >= {2'b0, cfg.limit});
        div_total <= (total == '0) ? 16'd1 : total;
      end

      if (state == ST_HDR && push_ok) begin
        hcnt <= hcnt + 2'd1;
        if (hcnt == 2'd3) header_sent <= 1'b1;
      end

      // sweep: read every count, accumulate cumulative bounds, write back
      pipe_v <= 1'b0;
      if (state == ST_SWEEP && issue != (IDX_W+1)'(ALPHABET)) begin
        rd_v     <= valid_bits[issue[IDX_W-1:0]];
        pipe_idx <= issue[IDX_W-1:0];
        pipe_v   <= 1'b1;
        issue    <= issue + (IDX_W+1)'(1);
      end
      if (pipe_v) begin
        valid_bits[pipe_idx] <= 1'b1;
        acc_sum   <= acc_sum + cnt;
        total_acc <= total_acc + nval;
        if (pipe_idx == sym) begin
          cum_lo <= acc_sum;
          cum_hi <= acc_sum + cnt;
        end
      end
      if (state == ST_SWEEP && sweep_end) total <= total_acc;

      if (state == ST_DIV && div_done) begin
        if (!mul_sel) begin
          q_hi    <= div_q;
          mul_sel <= 1'b1;
        end else begin
          lo    <= lo + div_q;
          hi    <= lo + q_hi - 16'd1;
          k_cnt <= '0;
        end
      end

      if (emit_fire) begin
        fill <= fill + 3'd1;
        acc  <= (fill == 3'd7) ? '0 : {acc[6:0], emit_val};
      end

      if (state == ST_RENORM && k_cnt != 5'd16) begin
        if (eq_top) begin
          if (emit_fire) bitval <= ~lo[15];
        end else if (underflow) begin
          pending <= pend_inc;
          if (pend_inc >= PW'(PENDING_MAX)) ovf_seen <= 1'b1;
          lo    <= (lo & ~SECOND_MASK) << 1;
          hi    <= ((hi | SECOND_MASK) << 1) | 16'd1;
          k_cnt <= k_cnt + 5'd1;
        end
      end

      if (state == ST_PEND) begin
        if (pending != '0) begin
          if (emit_fire) pending <= pending - PW'(1);
        end else if (!fin) begin
          lo    <= lo << 1;
          hi    <= (hi << 1) | 16'd1;
          k_cnt <= k_cnt + 5'd1;
        end
      end

      if (state == ST_FIN && emit_fire) begin
        bitval  <= ~lo[14];
        pending <= pending + PW'(1);
      end

      // output side: hold the newest byte until the item's last is known
      out_valid <= out_valid && !m_tready;
      if (push_fire) begin
        if (hold_valid) begin
          out_valid <= 1'b1;
          out_byte  <= hold_byte;
          out_ovf   <= hold_ovf;
          out_last  <= 1'b0;
          out_eos   <= 1'b0;
        end
        hold_valid <= 1'b1;
        hold_byte  <= push_data;
        hold_ovf   <= ovf_seen;
      end else if (flush_fire && hold_valid) begin
        out_valid  <= 1'b1;
        out_byte   <= hold_byte;
        out_ovf    <= hold_ovf;
        out_last   <= 1'b1;
        out_eos    <= fin;
        hold_valid <= 1'b0;
      end

      // finish: drop the stream state back to its start
      if (flush_fire && fin) begin
        valid_bits  <= '0;
        header_sent <= 1'b0;
        ovf_seen    <= 1'b0;
        lo          <= '0;
        hi          <= HIGH_RESET;
        pending     <= '0;
        acc         <= '0;
        fill        <= '0;
        total       <= CNT_W'(ALPHABET);
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_byte;
  assign m_tlast  = out_last;
  assign m_tuser  = {out_ovf, out_eos};

  `AAE_ASSERT(a_hold_empty_idle, (state == ST_IDLE) |-> !hold_valid, "byte held across items")
  `AAE_ASSERT(a_shift_bound, k_cnt <= 5'd16, "renormalization ran past sixteen shifts")
  `AAE_ASSERT(a_eos_is_last, (out_valid && out_eos) |-> out_last, "end of stream not on last byte")

endmodule

FILE: hdl/adaptive_arithmetic_encoder_unit.sv
// Channel   Direction  Payload
// s_*       in         tdata[7:0] symbol; tuser[0] operation (0 code, 1 finish)
// m_*       out        tdata[7:0] out_byte; tlast last_of_item;
//                      tuser[0] end_of_stream, tuser[1] pending_overflow
// APB       in/out     0x0 stream_length, 0x4 count_increment, 0x8 rescale_limit
//
// A coded symbol makes one pass over the count memory (one entry per cycle),
// two 32-step divisions, then renormalization shifts and emitted bits, where
// emitted bits wait while the output is stalled. The header is four bytes.
// A finish emits its bits and pads the last byte. Reset: rst, synchronous, no
// clearing pass (per-entry valid bits). Input requests queue two deep; an
// output register and a one-byte hold decouple the output from the coder.
module adaptive_arithmetic_encoder_unit
  import aae_pkg::*;
#(
  parameter int ALPHABET    = 256,
  parameter int PENDING_MAX = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] symbol
  input  logic        s_tuser,   // [0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast,
  output logic [1:0]  m_tuser,   // [0] end_of_stream, [1] pending_overflow
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  aae_cfg_t  cfg;
  logic      q_valid, q_pop;
  aae_item_t q_item;
  logic      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // config registers; to be written only while the coder is idle (not enforced by the block)
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.length <= '0;
      cfg.incr   <= 6'd32;
      cfg.limit  <= 14'd16383;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_LENGTH: cfg.length <= pwdata;
        REG_INCR:   cfg.incr   <= pwdata[5:0];
        REG_LIMIT:  cfg.limit  <= pwdata[13:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LENGTH: prdata = cfg.length;
      REG_INCR:   prdata = {26'b0, cfg.incr};
      REG_LIMIT:  prdata = {18'b0, cfg.limit};
      default:    prdata = '0;
    endcase
  end

  // front: take requests, clamp symbols, queue them
  aae_front #(.ALPHABET(ALPHABET)) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // back: model sweep, interval arithmetic, bit packing, output
  aae_back #(.ALPHABET(ALPHABET), .PENDING_MAX(PENDING_MAX)) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

FILE: tb/sv/adaptive_arithmetic_encoder_unit_tb.sv
`timescale 1ns / 1ps

module adaptive_arithmetic_encoder_unit_tb;
  import aae_pkg::*;

  localparam int NSYM        = 256;
  localparam int PEND_LIMIT  = 256;
  localparam int BYTE_CAP    = 64;
  localparam int CYCLE_LIMIT = 1500000;
  // the input queue holds two requests, so this many cycles drains any queued
  // work that makes no byte
  localparam int SETTLE      = 1200;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       eos;
    logic       ovf;
  } coded_byte_t;

  // Predicts the coded byte stream and checks it against the block
  class byte_scoreboard;
    logic [31:0] length;
    logic [5:0]  incr;
    logic [13:0] limit;
    logic [15:0] lo_b, hi_b;
    int          pend, acc, fill;
    logic [15:0] cnt[NSYM];
    logic [15:0] cum[NSYM+1];
    bit          hdr_done, ovf_seen;
    coded_byte_t item_bytes[$];
    coded_byte_t expected_bytes[$];
    int          errors;

    function new();
      length = 0; incr = 32; limit = 16383; errors = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      lo_b = 16'h0000; hi_b = HIGH_RESET; pend = 0; acc = 0; fill = 0;
      for (int i = 0; i < NSYM; i++) cnt[i] = 16'd1;
      for (int i = 0; i <= NSYM; i++) cum[i] = 16'(i);
      hdr_done = 0; ovf_seen = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_LENGTH: length = val;
        REG_INCR:   incr   = val[5:0];
        REG_LIMIT:  limit  = val[13:0];
        default: ;
      endcase
    endfunction

    function void add_byte(int b);
      coded_byte_t e;
      if (item_bytes.size() < BYTE_CAP) begin
        e.data = 8'(b); e.last = 0; e.eos = 0; e.ovf = ovf_seen;
        item_bytes.push_back(e);
      end
    endfunction

    function void add_bit(int b);
      acc = ((acc << 1) | (b & 1)) & 8'hFF;
      fill++;
      if (fill == 8) begin
        add_byte(acc);
        acc = 0; fill = 0;
      end
    endfunction

    function void narrow(int s);
      longint unsigned tot, rng, lo, hi;
      int top;
      tot = cum[NSYM];
      if (tot == 0) tot = 1;
      // range and products wrap at 32 bits
      rng = (longint'(hi_b) - longint'(lo_b) + 1) & 32'hFFFF_FFFF;
      lo  = lo_b;
      hi  = (lo + ((rng * cum[s+1]) & 32'hFFFF_FFFF) / tot - 1) & 16'hFFFF;
      lo  = (lo + ((rng * cum[s]) & 32'hFFFF_FFFF) / tot) & 16'hFFFF;
      for (int k = 0; k < 16; k++) begin
        if ((lo & TOP_MASK) == (hi & TOP_MASK)) begin
          top = (lo & TOP_MASK) != 0;
          add_bit(top);
          while (pend > 0) begin
            add_bit(top ^ 1);
            pend--;
          end
        end else if ((lo & ~hi & SECOND_MASK) != 0) begin
          if (pend < PEND_LIMIT) pend++;
          if (pend >= PEND_LIMIT) ovf_seen = 1;
          lo = lo & ~longint'(SECOND_MASK);
          hi = hi | SECOND_MASK;
        end else begin
          break;
        end
        lo = (lo << 1) & 16'hFFFF;
        hi = ((hi << 1) | 1) & 16'hFFFF;
      end
      lo_b = 16'(lo); hi_b = 16'(hi);
    endfunction

    function void adapt(int s);
      if (cum[NSYM] >= limit) begin
        cum[0] = 0;
        for (int i = 0; i < NSYM; i++) begin
          cnt[i] = 16'((32'(cnt[i]) + 1) / 2);
          cum[i+1] = cum[i] + cnt[i];
        end
      end
      cnt[s] = cnt[s] + incr;
      for (int i = s + 1; i <= NSYM; i++) cum[i] = cum[i] + incr;
    endfunction

    // note an accepted request and queue the bytes it should produce
    function void note_request(logic op, logic [7:0] sym);
      int s, b;
      item_bytes.delete();
      if (!hdr_done) begin
        for (int i = 0; i < 4; i++) add_byte(int'((length >> (8*i)) & 8'hFF));
        hdr_done = 1;
      end
      if (op == OP_CODE) begin
        s = (sym >= NSYM) ? NSYM - 1 : sym;
        narrow(s);
        adapt(s);
        if (item_bytes.size() > 0) item_bytes[$].last = 1;
      end else begin
        b = (lo_b & SECOND_MASK) != 0;
        add_bit(b);
        for (int n = pend + 1; n > 0; n--) add_bit(b ^ 1);
        while (fill != 0) add_bit(1);
        if (item_bytes.size() > 0) begin
          item_bytes[$].last = 1;
          item_bytes[$].eos  = 1;
        end
        clear_stream();
      end
      foreach (item_bytes[i]) expected_bytes.push_back(item_bytes[i]);
    endfunction

    function void check_byte(logic [7:0] d, logic l, logic e, logic o);
      coded_byte_t x;
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected byte data=%h last=%b eos=%b ovf=%b", $time, d, l, e, o);
        errors++;
        return;
      end
      x = expected_bytes.pop_front();
      if (d !== x.data) begin
        $display("%0t: out_byte expected %h actual %h", $time, x.data, d);
        errors++;
      end
      if (l !== x.last) begin
        $display("%0t: last_of_item expected %b actual %b", $time, x.last, l);
        errors++;
      end
      if (e !== x.eos) begin
        $display("%0t: end_of_stream expected %b actual %b", $time, x.eos, e);
        errors++;
      end
      if (o !== x.ovf) begin
        $display("%0t: pending_overflow expected %b actual %b", $time, x.ovf, o);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [7:0]  s_tdata = 0;
  logic        s_tuser = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic [1:0]  m_tuser;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [3:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;

  byte_scoreboard sb = new();
  int  cycles = 0;
  int  req_count = 0;
  bit  steady = 0;   // set for a long run with no idling on either side

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  adaptive_arithmetic_encoder_unit u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  // watchdog: end the run with a failure once the cycle count passes CYCLE_LIMIT
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL adaptive_arithmetic_encoder_unit");
      $finish;
    end
  end

  // stall the output side at random, except in the steady stretch
  always @(posedge clk) begin
    if (rst) m_tready <= 0;
    else     m_tready <= steady || ($urandom_range(99) >= 34);
  end

  // check every accepted output byte against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_byte(m_tdata, m_tlast, m_tuser[0], m_tuser[1]);
  end

  // offer one request; tvalid stays high across back-to-back requests and
  // drops only on an idle cycle, so it never gets two assignments in a step
  task automatic send_request(logic op, logic [7:0] sym);
    while (!steady && $urandom_range(99) < 34) begin
      s_tvalid <= 0;
      s_tdata  <= 8'($urandom);
      s_tuser  <= 1'($urandom);
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= sym;
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    sb.note_request(op, sym);
    req_count++;
  endtask

  // hold off until every predicted byte is out and the coder has settled
  task automatic drain();
    s_tvalid <= 0;
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle
  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.write_reg(idx, val);
  endtask

  task automatic set_config(logic [31:0] len, logic [5:0] inc, logic [13:0] lim);
    apb_write(REG_LENGTH, len);
    apb_write(REG_INCR, 32'(inc));
    apb_write(REG_LIMIT, 32'(lim));
    @(posedge clk);
  endtask

  // random traffic: mostly well-formed streams closed by a finish, with
  // a skewed alphabet now and then so counts pile up and get rescaled,
  // plus stray finishes as noise
  task automatic random_phase(int n);
    int left, run, mode;
    logic [7:0] s;
    left = n;
    while (left > 0) begin
      run  = $urandom_range(40, 1);
      mode = $urandom_range(2);
      for (int i = 0; i < run && left > 0; i++) begin
        steady = (req_count >= 180 && req_count < 260);
        case (mode)
          0: s = 8'($urandom);
          1: s = 8'($urandom_range(3));
          default: s = ($urandom_range(1)) ? 8'd127 : 8'd128;
        endcase
        if ($urandom_range(29) == 0) send_request(OP_FINISH, 8'($urandom));
        else                         send_request(OP_CODE, s);
        left--;
      end
      send_request(OP_FINISH, 8'($urandom));
      left--;
    end
    steady = 0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: finish on an empty stream, alphabet edges, near-middle pairs
    send_request(OP_FINISH, 8'hFF);
    send_request(OP_CODE, 8'h00);
    send_request(OP_CODE, 8'hFF);
    send_request(OP_CODE, 8'h00);
    send_request(OP_FINISH, 8'h00);
    for (int i = 0; i < 14; i++) send_request(OP_CODE, (i % 2) ? 8'd128 : 8'd127);
    send_request(OP_CODE, 8'hFF);
    send_request(OP_FINISH, 8'h5A);
    drain();

    // extremes: largest header value, increment of one, limit of 512
    set_config(32'hFFFF_FFFF, 6'd1, 14'd512);
    send_request(OP_CODE, 8'hAA);
    send_request(OP_CODE, 8'h55);
    send_request(OP_FINISH, 8'h00);
    random_phase(100);
    drain();

    set_config(32'h0000_0000, 6'd32, 14'd512);
    random_phase(100);
    drain();

    set_config($urandom, 6'($urandom_range(32, 1)), 14'($urandom_range(16383, 512)));
    random_phase(105);
    drain();

    set_config($urandom, 6'd32, 14'd16383);
    random_phase(105);
    drain();

    if (sb.errors == 0) begin
      $display("PASS adaptive_arithmetic_encoder_unit");
    end else begin
      $display("FAIL adaptive_arithmetic_encoder_unit");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/aae_pkg.sv
hdl/aae_front.sv
hdl/aae_div.sv
hdl/aae_back.sv
hdl/adaptive_arithmetic_encoder_unit.sv
tb/sv/adaptive_arithmetic_encoder_unit_tb.sv
